/* design/h4va_pkg.sv */
// h4va_pkg: shared types, codes and defaults of the four-dimensional hough vote accumulator
// no dependencies; imported by h4va_ram users and the top level
package h4va_pkg;

    // default parameter values
    localparam int BIN_LEVELS_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // fixed field widths
    localparam int MODE_W     = 2;
    localparam int IDX_W      = 4;
    localparam int BINS_W     = 5;
    localparam int THR_W      = 16;
    localparam int OUT_CNT_W  = 16;
    localparam int KEPT_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [BINS_W-1:0] BINS_RESET      = 5'd10;
    localparam logic [THR_W-1:0]  MIN_VOTES_RESET = 16'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_BINS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_BINS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_BINS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_BINS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOTES   = 3'd4;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_VOTE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PRUNE = 2'd3;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MODIFY,
        ST_CLEAR,
        ST_PRUNE,
        ST_DONE
    } state_t;

endpackage

/* design/hough_4d_vote_accumulator_unit.sv */
// hough_4d_vote_accumulator_unit: four-dimensional hough vote counter store with a sequencer
// depends on h4va_pkg and h4va_ram
//
// usage
//   input channel s_*: one transaction carries a mode and four bin indices
//     vote: increment the bin (saturating) and return its new count
//     query: return the bin count; out-of-range bins (vote or query) give in_range 0, count 0
//     clear: zero every counter; prune: zero active bins below min_votes and
//     return the number kept and the largest count
//   result channel m_*: exactly one result transaction per input transaction
//   cfg_*: plain register writes, to be issued only while the block is idle
// operation sequence
//   vote / query: ram read at accept, modify-write once the output register is free
//   clear: all 2^(4*B) ram rows zeroed, one ram row written per cycle
//   prune: one ram read per cycle over the active bins, write-back behind it
//   s_ready is high only while the sequencer is idle; one ram port pair sets the rate
// reset
//   after aresetn a clearing pass writes zero to all 2^(4*B) entries
//   (65536 entries at the defaults) with s_ready low; cfg writes are taken meanwhile
// stall
//   a finished result sits in the output register; the block goes idle and takes the
//   next transaction, but holds its next result until the receiver drains the first
module hough_4d_vote_accumulator_unit
    import h4va_pkg::*;
#(
    parameter int BIN_LEVELS  = BIN_LEVELS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [MODE_W-1:0]     s_mode,
    input  logic [IDX_W-1:0]      s_scale_bin,
    input  logic [IDX_W-1:0]      s_orient_bin,
    input  logic [IDX_W-1:0]      s_x_bin,
    input  logic [IDX_W-1:0]      s_y_bin,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_in_range,
    output logic [OUT_CNT_W-1:0]  m_count,
    output logic [KEPT_W-1:0]     m_kept_bins,
    output logic [OUT_CNT_W-1:0]  m_max_count,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // bits per bin dimension, packed ram address of four dimensions
    localparam int B      = (BIN_LEVELS > 1) ? $clog2(BIN_LEVELS) : 1;
    localparam int AW     = B + 1;
    localparam int ADDR_W = 4 * B;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CW     = COUNT_WIDTH;
    localparam int MW     = (CW > THR_W) ? CW : THR_W;

    // configuration registers
    logic [BINS_W-1:0] scale_bins_reg, orient_bins_reg, x_bins_reg, y_bins_reg;
    logic [THR_W-1:0]  min_votes_reg;

    // sequencer and datapath registers
    state_t              state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [B-1:0]        s_idx_reg, s_idx_next, o_idx_reg, o_idx_next;
    logic [B-1:0]        x_idx_reg, x_idx_next, y_idx_reg, y_idx_next;
    logic                walk_done_reg, walk_done_next;
    logic                prune_vld_reg, prune_vld_next;
    logic [ADDR_W-1:0]   prune_addr_reg, prune_addr_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [KEPT_W-1:0]   kept_reg, kept_next;
    logic [CW-1:0]       max_reg, max_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic                 in_range_reg, in_range_next;
    logic [OUT_CNT_W-1:0] count_reg, count_next;
    logic [KEPT_W-1:0]    kept_out_reg, kept_out_next;
    logic [OUT_CNT_W-1:0] max_out_reg, max_out_next;

    // ram interface
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CW-1:0]     ram_wdata, ram_rdata;

    // misc combinational
    logic [AW-1:0]     act_s, act_o, act_x, act_y;
    logic              any_zero, in_range, accept, out_free, issue;
    logic              s_last, o_last, x_last, y_last;
    logic [ADDR_W-1:0] port_addr, walk_addr;
    logic [CW-1:0]     vote_val;
    logic              keep_bin;

    // active count: register value capped at BIN_LEVELS
    function automatic logic [AW-1:0] act_f(input logic [BINS_W-1:0] c);
        if (int'(c) > BIN_LEVELS) begin
            return AW'(BIN_LEVELS);
        end
        return AW'(c);
    endfunction

    function automatic logic idx_ok(input logic [IDX_W-1:0] i, input logic [BINS_W-1:0] c);
        return (BINS_W'(i) < c) && (int'(i) < BIN_LEVELS);
    endfunction

    assign act_s    = act_f(scale_bins_reg);
    assign act_o    = act_f(orient_bins_reg);
    assign act_x    = act_f(x_bins_reg);
    assign act_y    = act_f(y_bins_reg);
    assign any_zero = (act_s == '0) || (act_o == '0) || (act_x == '0) || (act_y == '0);

    assign in_range = idx_ok(s_scale_bin, scale_bins_reg) && idx_ok(s_orient_bin, orient_bins_reg)
                   && idx_ok(s_x_bin, x_bins_reg) && idx_ok(s_y_bin, y_bins_reg);

    assign port_addr = {B'(s_y_bin), B'(s_x_bin), B'(s_orient_bin), B'(s_scale_bin)};
    assign walk_addr = {y_idx_reg, x_idx_reg, o_idx_reg, s_idx_reg};

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign issue    = (state_reg == ST_PRUNE) && !walk_done_reg;

    assign s_last = (AW'(s_idx_reg) + AW'(1)) == act_s;
    assign o_last = (AW'(o_idx_reg) + AW'(1)) == act_o;
    assign x_last = (AW'(x_idx_reg) + AW'(1)) == act_x;
    assign y_last = (AW'(y_idx_reg) + AW'(1)) == act_y;

    // saturating increment for vote, plain read for query
    assign vote_val = (mode_reg == MODE_VOTE && !(&ram_rdata)) ? ram_rdata + CW'(1) : ram_rdata;
    assign keep_bin = MW'(ram_rdata) >= MW'(min_votes_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_bins_reg  <= BINS_RESET;
            orient_bins_reg <= BINS_RESET;
            x_bins_reg      <= BINS_RESET;
            y_bins_reg      <= BINS_RESET;
            min_votes_reg   <= MIN_VOTES_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SCALE_BINS:  scale_bins_reg  <= cfg_wdata[BINS_W-1:0];
                CFG_ORIENT_BINS: orient_bins_reg <= cfg_wdata[BINS_W-1:0];
                CFG_X_BINS:      x_bins_reg      <= cfg_wdata[BINS_W-1:0];
                CFG_Y_BINS:      y_bins_reg      <= cfg_wdata[BINS_W-1:0];
                CFG_MIN_VOTES:   min_votes_reg   <= cfg_wdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (&clr_addr_reg) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_mode)
                        MODE_VOTE, MODE_QUERY: state_next = in_range ? ST_MODIFY : ST_DONE;
                        MODE_CLEAR:            state_next = ST_CLEAR;
                        MODE_PRUNE:            state_next = any_zero ? ST_DONE : ST_PRUNE;
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MODIFY: begin
                if (out_free) state_next = ST_IDLE;
            end
            ST_CLEAR: begin
                if (&clr_addr_reg) state_next = ST_DONE;
            end
            ST_PRUNE: begin
                if (walk_done_reg && !prune_vld_reg) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        mode_next       = mode_reg;
        addr_next       = addr_reg;
        s_idx_next      = s_idx_reg;
        o_idx_next      = o_idx_reg;
        x_idx_next      = x_idx_reg;
        y_idx_next      = y_idx_reg;
        walk_done_next  = walk_done_reg;
        prune_vld_next  = 1'b0;
        prune_addr_next = prune_addr_reg;
        clr_addr_next   = clr_addr_reg;
        kept_next       = kept_reg;
        max_next        = max_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        in_range_next   = in_range_reg;
        count_next      = count_reg;
        kept_out_next   = kept_out_reg;
        max_out_next    = max_out_reg;

        unique case (state_reg)
            ST_INIT, ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    mode_next      = s_mode;
                    addr_next      = port_addr;
                    s_idx_next     = '0;
                    o_idx_next     = '0;
                    x_idx_next     = '0;
                    y_idx_next     = '0;
                    walk_done_next = 1'b0;
                    clr_addr_next  = '0;
                    kept_next      = '0;
                    max_next       = '0;
                end
            end
            ST_MODIFY: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    in_range_next = 1'b1;
                    count_next    = OUT_CNT_W'(vote_val);
                    kept_out_next = '0;
                    max_out_next  = '0;
                end
            end
            ST_PRUNE: begin
                // walk bins in s, o, x, y order, one read per cycle
                if (issue) begin
                    prune_vld_next  = 1'b1;
                    prune_addr_next = walk_addr;
                    s_idx_next      = s_last ? '0 : s_idx_reg + B'(1);
                    if (s_last) begin
                        o_idx_next = o_last ? '0 : o_idx_reg + B'(1);
                        if (o_last) begin
                            x_idx_next = x_last ? '0 : x_idx_reg + B'(1);
                            if (x_last) begin
                                y_idx_next = y_last ? '0 : y_idx_reg + B'(1);
                                if (y_last) walk_done_next = 1'b1;
                            end
                        end
                    end
                end
                // data of the previous read is back
                if (prune_vld_reg) begin
                    if (ram_rdata > max_reg) max_next = ram_rdata;
                    if (keep_bin) kept_next = kept_reg + KEPT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    in_range_next = 1'b0;
                    count_next    = '0;
                    kept_out_next = kept_reg;
                    max_out_next  = OUT_CNT_W'(max_reg);
                end
            end
            default: begin
            end
        endcase
    end

    // outputs: handshake and ram control
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        ram_re    = 1'b0;
        ram_raddr = port_addr;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = vote_val;
        unique case (state_reg)
            ST_INIT, ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                ram_re = accept;
            end
            ST_MODIFY: begin
                ram_we = out_free && (mode_reg == MODE_VOTE);
            end
            ST_PRUNE: begin
                ram_re    = issue;
                ram_raddr = walk_addr;
                ram_we    = prune_vld_reg && !keep_bin;
                ram_waddr = prune_addr_reg;
                ram_wdata = '0;
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            clr_addr_reg  <= '0;
            walk_done_reg <= 1'b1;
            prune_vld_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            walk_done_reg <= walk_done_next;
            prune_vld_reg <= prune_vld_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        addr_reg       <= addr_next;
        s_idx_reg      <= s_idx_next;
        o_idx_reg      <= o_idx_next;
        x_idx_reg      <= x_idx_next;
        y_idx_reg      <= y_idx_next;
        prune_addr_reg <= prune_addr_next;
        kept_reg       <= kept_next;
        max_reg        <= max_next;
        in_range_reg   <= in_range_next;
        count_reg      <= count_next;
        kept_out_reg   <= kept_out_next;
        max_out_reg    <= max_out_next;
    end

    h4va_ram #(
        .WIDTH (CW),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_valid     = m_valid_reg;
    assign m_in_range  = in_range_reg;
    assign m_count     = count_reg;
    assign m_kept_bins = kept_out_reg;
    assign m_max_count = max_out_reg;

`ifndef NO_ASSERTIONS
    // one transaction at a time: the sequencer leaves idle after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("accepted a transaction while the previous one was in flight");

    // a result is loaded only from a finishing state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_MODIFY || $past(state_reg) == ST_DONE))
        else $error("result appeared without a finishing state");

    // prune write-back only for a bin whose read data is back
    a_prune_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PRUNE && ram_we) |-> (prune_vld_reg && ram_wdata == '0))
        else $error("prune wrote a bin without valid read data");

    // a query never writes the store
    a_query_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MODIFY && ram_we) |-> (mode_reg == MODE_VOTE))
        else $error("store written on a query");
`endif

endmodule

/* design/h4va_ram.sv */
// h4va_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module h4va_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
